### hw/rtl/refcounted_page_allocator_assert.svh
// assertion macros for the page allocator rtl
// no dependencies; included by modules that carry checks
`ifndef REFCOUNTED_PAGE_ALLOCATOR_ASSERT_SVH
`define REFCOUNTED_PAGE_ALLOCATOR_ASSERT_SVH

// same-cycle implication under synchronous active-low reset
`define RPA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rpa: check failed");

// next-cycle implication under synchronous active-low reset
`define RPA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rpa: check failed");

`endif

### hw/rtl/rpa_pkg.sv
// shared types, codes and helpers for the reference-counted page allocator
// no dependencies; imported by the top level, rpa_front and rpa_back
`default_nettype none

package rpa_pkg;

    // default sizing
    localparam int NUM_PAGES_DEF  = 32768;
    localparam int PAGE_SHIFT_DEF = 12;
    localparam int COUNT_BITS_DEF = 8;

    // register indexes (selected by paddr[2])
    localparam logic [0:0] REG_LOW_BOUND  = 1'b0;
    localparam logic [0:0] REG_HIGH_BOUND = 1'b1;

    // operation codes of an input item
    localparam logic [2:0] OP_ALLOC   = 3'd0;
    localparam logic [2:0] OP_RELEASE = 3'd1;
    localparam logic [2:0] OP_ADD_REF = 3'd2;
    localparam logic [2:0] OP_GET_REF = 3'd3;
    localparam logic [2:0] OP_DONATE  = 3'd4;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_ADDR  = 3'd1,
        ST_NOT_REF   = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_SATURATED = 3'd4
    } t_status;

    // classified command as handed from front to back
    typedef enum logic [2:0] {
        K_ALLOC,
        K_RELEASE,
        K_ADD_REF,
        K_GET_REF,
        K_DONATE,
        K_BAD_ADDR,
        K_UNKNOWN
    } t_kind;

    // back end sequencer states
    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    // back end status seen by the front
    typedef struct packed {
        logic clearing;
    } t_back_stat;

    // low bound rounded up to a page boundary, 33 bits to keep the carry
    function automatic logic [32:0] f_page_base(input logic [31:0] low, input int shift);
        logic [32:0] mask;
        mask = (33'd1 << shift) - 33'd1;
        return ({1'b0, low} + mask) & ~mask;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/rpa_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module rpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32768
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### hw/rtl/rpa_queue.sv
// two-entry fifo of classified commands between front and back
// no dependencies
`default_nettype none

module rpa_queue #(
    parameter int WIDTH = 18
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    output logic                  o_valid,
    output logic      [WIDTH-1:0] o_data,
    input  wire logic             i_pop
);

    logic [WIDTH-1:0] r_slot [2];
    logic             r_wptr;
    logic             r_rptr;
    logic [1:0]       r_count;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_data;
        end
    end

    assign o_full  = r_count == 2'd2;
    assign o_valid = r_count != 2'd0;
    assign o_data  = r_slot[r_rptr];

endmodule

`default_nettype wire

### hw/rtl/rpa_front.sv
// front end: accepts items, checks the address and classifies the operation
// depends on rpa_pkg
`default_nettype none

module rpa_front #(
    parameter int NUM_PAGES  = 32768,
    parameter int PAGE_SHIFT = 12
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [2:0]                   i_operation,
    input  wire logic [31:0]                  i_page_address,
    input  wire logic [31:0]                  i_low_bound,
    input  wire logic [31:0]                  i_high_bound,
    input  wire rpa_pkg::t_back_stat          i_stat,
    input  wire logic                         i_full,
    output logic                              o_push,
    output rpa_pkg::t_kind                    o_kind,
    output logic [$clog2(NUM_PAGES)-1:0]      o_idx
);

    import rpa_pkg::*;

    localparam int          IDX_W     = $clog2(NUM_PAGES);
    localparam logic [31:0] PAGE_MASK = (32'd1 << PAGE_SHIFT) - 32'd1;

    logic              r_valid;
    t_kind             r_kind;
    logic [IDX_W-1:0]  r_idx;
    logic              accept;
    logic              addr_ok;
    logic [32:0]       base;
    logic [32:0]       rel;
    t_kind             kind;

    // address check and table index relative to the page base
    always_comb begin
        base    = f_page_base(i_low_bound, PAGE_SHIFT);
        rel     = ({1'b0, i_page_address} - base) >> PAGE_SHIFT;
        addr_ok = ((i_page_address & PAGE_MASK) == 32'd0)
               && (i_page_address >= i_low_bound)
               && (i_page_address < i_high_bound)
               && (rel < 33'(NUM_PAGES));
    end

    // classify the operation
    always_comb begin
        case (i_operation)
            OP_ALLOC:   kind = K_ALLOC;
            OP_RELEASE: kind = K_RELEASE;
            OP_ADD_REF: kind = K_ADD_REF;
            OP_GET_REF: kind = K_GET_REF;
            OP_DONATE:  kind = K_DONATE;
            default:    kind = K_UNKNOWN;
        endcase
        if (!addr_ok && !(kind inside {K_ALLOC, K_UNKNOWN})) begin
            kind = K_BAD_ADDR;
        end
    end

    // handshake: hold off during the clearing pass or while the stage is blocked
    assign o_in_stall = i_stat.clearing || (r_valid && i_full);
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = r_valid && !i_full;

    // classified item stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= kind;
            r_idx  <= rel[IDX_W-1:0];
        end
    end

    assign o_kind = r_kind;
    assign o_idx  = r_idx;

endmodule

`default_nettype wire

### hw/rtl/rpa_back.sv
// back end: count table and free stack, read-modify-write sequencer, result register
// depends on rpa_pkg, rpa_ram and the assertion macro header
`default_nettype none

module rpa_back #(
    parameter int NUM_PAGES  = 32768,
    parameter int PAGE_SHIFT = 12,
    parameter int COUNT_BITS = 8
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [31:0]                  i_low_bound,
    input  wire logic                         i_q_valid,
    input  wire rpa_pkg::t_kind               i_q_kind,
    input  wire logic [$clog2(NUM_PAGES)-1:0] i_q_idx,
    output logic                              o_pop,
    output rpa_pkg::t_back_stat               o_stat,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic [2:0]                        o_status,
    output logic [31:0]                       o_granted_address,
    output logic [7:0]                        o_count_now,
    output logic                              o_page_freed
);

    import rpa_pkg::*;

    `include "refcounted_page_allocator_assert.svh"

    localparam int IDX_W   = $clog2(NUM_PAGES);
    localparam int DEPTH_W = $clog2(NUM_PAGES + 1);
    localparam int SHOW_W  = (COUNT_BITS > 8) ? COUNT_BITS : 8;
    localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

    // count as shown on the result, saturated to eight bits
    function automatic logic [7:0] f_shown(input logic [COUNT_BITS-1:0] c);
        logic [SHOW_W-1:0] ce;
        ce = SHOW_W'(c);
        if (ce > SHOW_W'(255)) begin
            return 8'hFF;
        end
        return ce[7:0];
    endfunction

    t_state                r_state;
    t_state                n_state;
    logic [IDX_W-1:0]      r_clr_cnt;
    t_kind                 r_kind;
    logic [IDX_W-1:0]      r_idx;
    logic [DEPTH_W-1:0]    r_depth;
    logic [DEPTH_W-1:0]    n_depth;
    logic                  r_out_valid;
    t_status               r_status;
    logic [31:0]           r_granted;
    logic [7:0]            r_count;
    logic                  r_freed;

    logic                  out_free;
    logic                  done;
    logic [COUNT_BITS-1:0] cnt_rd;
    logic [IDX_W-1:0]      stk_rd;
    logic [32:0]           base_full;
    logic [31:0]           base;

    // execute results
    t_status               x_status;
    logic [31:0]           x_granted;
    logic [7:0]            x_count;
    logic                  x_freed;
    logic                  x_ref_wr;
    logic [IDX_W-1:0]      x_ref_addr;
    logic [COUNT_BITS-1:0] x_ref_data;
    logic                  x_push;
    logic [COUNT_BITS-1:0] new_c;

    // memory controls
    logic                  ref_we;
    logic [IDX_W-1:0]      ref_waddr;
    logic [COUNT_BITS-1:0] ref_wdata;
    logic                  stk_we;
    logic [IDX_W-1:0]      stk_waddr;
    logic                  mem_re;
    logic [IDX_W-1:0]      stk_raddr;

    rpa_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NUM_PAGES)
    ) u_ref_ram (
        .i_clk   (i_clk),
        .i_we    (ref_we),
        .i_waddr (ref_waddr),
        .i_wdata (ref_wdata),
        .i_re    (mem_re),
        .i_raddr (i_q_idx),
        .o_rdata (cnt_rd)
    );

    rpa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (NUM_PAGES)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (r_idx),
        .i_re    (mem_re),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rd)
    );

    assign out_free  = !r_out_valid || !i_out_stall;
    assign base_full = f_page_base(i_low_bound, PAGE_SHIFT);
    assign base      = base_full[31:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_cnt == IDX_W'(NUM_PAGES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_q_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // execute: work on the count read from the table and the top of the free stack
    always_comb begin
        x_status   = ST_OK;
        x_granted  = 32'd0;
        x_count    = 8'd0;
        x_freed    = 1'b0;
        x_ref_wr   = 1'b0;
        x_ref_addr = r_idx;
        x_ref_data = '0;
        x_push     = 1'b0;
        n_depth    = r_depth;
        new_c      = cnt_rd;
        case (r_kind)
            K_ALLOC: begin
                if (r_depth == '0) begin
                    x_status = ST_EMPTY;
                end else begin
                    n_depth    = r_depth - DEPTH_W'(1);
                    x_ref_wr   = 1'b1;
                    x_ref_addr = stk_rd;
                    x_ref_data = COUNT_BITS'(1);
                    x_granted  = base + (32'(stk_rd) << PAGE_SHIFT);
                    x_count    = 8'd1;
                end
            end
            K_RELEASE: begin
                if (cnt_rd == '0) begin
                    x_status = ST_NOT_REF;
                end else begin
                    new_c      = cnt_rd - COUNT_BITS'(1);
                    x_ref_wr   = 1'b1;
                    x_ref_data = new_c;
                    x_count    = f_shown(new_c);
                    x_push     = new_c == '0;
                end
            end
            K_ADD_REF: begin
                if (cnt_rd == CMAX) begin
                    x_status = ST_SATURATED;
                    x_count  = f_shown(CMAX);
                end else begin
                    new_c      = cnt_rd + COUNT_BITS'(1);
                    x_ref_wr   = 1'b1;
                    x_ref_data = new_c;
                    x_count    = f_shown(new_c);
                end
            end
            K_GET_REF: begin
                x_count = f_shown(cnt_rd);
            end
            K_DONATE: begin
                x_ref_wr = 1'b1;
                x_push   = 1'b1;
            end
            K_BAD_ADDR: begin
                x_status = ST_BAD_ADDR;
            end
            default: begin
                x_status = ST_OK;
            end
        endcase
        // a push onto a full stack is dropped
        if (x_push && (r_depth < DEPTH_W'(NUM_PAGES))) begin
            n_depth = r_depth + DEPTH_W'(1);
            x_freed = 1'b1;
        end
    end

    // outputs of the sequencer
    always_comb begin
        o_pop     = 1'b0;
        mem_re    = 1'b0;
        done      = 1'b0;
        ref_we    = 1'b0;
        ref_waddr = x_ref_addr;
        ref_wdata = x_ref_data;
        stk_we    = 1'b0;
        stk_waddr = r_depth[IDX_W-1:0];
        stk_raddr = IDX_W'(r_depth - DEPTH_W'(1));
        o_stat.clearing = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_stat.clearing = 1'b1;
                ref_we          = 1'b1;
                ref_waddr       = r_clr_cnt;
                ref_wdata       = '0;
            end
            S_IDLE: begin
                o_pop  = i_q_valid;
                mem_re = i_q_valid;
            end
            S_EXEC: begin
                done   = out_free;
                ref_we = out_free && x_ref_wr;
                stk_we = out_free && x_freed;
            end
            default: begin
                o_stat.clearing = 1'b1;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_cnt   <= '0;
            r_depth     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + IDX_W'(1);
            end
            if (done) begin
                r_depth     <= n_depth;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // command and result payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind <= i_q_kind;
            r_idx  <= i_q_idx;
        end
        if (done) begin
            r_status  <= x_status;
            r_granted <= x_granted;
            r_count   <= x_count;
            r_freed   <= x_freed;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_granted_address = r_granted;
    assign o_count_now       = r_count;
    assign o_page_freed      = r_freed;

    // checks
    `RPA_ASSERT_IMP(a_depth_range, i_clk, i_rst_n, 1'b1, r_depth <= DEPTH_W'(NUM_PAGES))
    `RPA_ASSERT_IMP(a_no_pop_clear, i_clk, i_rst_n, r_state == S_CLEAR, !o_pop)
    `RPA_ASSERT_IMP(a_push_room, i_clk, i_rst_n, stk_we, r_depth < DEPTH_W'(NUM_PAGES))
    `RPA_ASSERT_NXT(a_exec_after_pop, i_clk, i_rst_n, o_pop, r_state == S_EXEC)

endmodule

`default_nettype wire

### hw/rtl/refcounted_page_allocator.sv
// Reference-counted page allocator top level: configuration registers, front end,
// command queue and back end; depends on rpa_pkg, rpa_front, rpa_queue, rpa_back.
// Each item (alloc, release, add_ref, get_ref, donate) gives exactly one result.
// In the back end the count table and the free stack are read when the command is
// taken from the queue (registered ram read) and written back when it executes;
// the back end takes no new item before the last is written back. From acceptance
// to a valid result an item passes the classify stage, the command queue,
// the step in which the back end takes the command from the queue and reads both
// memories, and the step to execute and register the result. After reset the back
// end clears the count table, one entry a cycle, all NUM_PAGES entries (32768 at
// the default size); no item is accepted during that pass, while register writes
// are taken as ever. Registers sit at byte address 0 (low_bound) and 4
// (high_bound) and should be written only while the block is idle.
`default_nettype none

module refcounted_page_allocator #(
    parameter int NUM_PAGES  = rpa_pkg::NUM_PAGES_DEF,
    parameter int PAGE_SHIFT = rpa_pkg::PAGE_SHIFT_DEF,
    parameter int COUNT_BITS = rpa_pkg::COUNT_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // input channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [2:0]  i_operation,
    input  wire logic [31:0] i_page_address,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic      [2:0]  o_status,
    output logic      [31:0] o_granted_address,
    output logic      [7:0]  o_count_now,
    output logic             o_page_freed
);

    import rpa_pkg::*;

    localparam int IDX_W = $clog2(NUM_PAGES);
    localparam int KIND_W = $bits(t_kind);
    localparam int CMD_W = KIND_W + IDX_W;

    logic [31:0]      r_low_bound;
    logic [31:0]      r_high_bound;
    logic             cfg_wr;
    t_back_stat       stat;
    logic             push;
    t_kind            f_kind;
    logic [IDX_W-1:0] f_idx;
    logic             q_full;
    logic             q_valid;
    logic [CMD_W-1:0] q_data;
    logic             pop;

    // configuration registers
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_bound  <= 32'd0;
            r_high_bound <= 32'h8800_0000;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_LOW_BOUND) begin
                r_low_bound <= pwdata;
            end else begin
                r_high_bound <= pwdata;
            end
        end
    end

    assign prdata = (paddr[2] == REG_HIGH_BOUND) ? r_high_bound : r_low_bound;

    // accept and classify
    rpa_front #(
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_page_address (i_page_address),
        .i_low_bound    (r_low_bound),
        .i_high_bound   (r_high_bound),
        .i_stat         (stat),
        .i_full         (q_full),
        .o_push         (push),
        .o_kind         (f_kind),
        .o_idx          (f_idx)
    );

    // command queue
    rpa_queue #(
        .WIDTH (CMD_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_kind, f_idx}),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_data),
        .i_pop   (pop)
    );

    // carry out
    rpa_back #(
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_SHIFT (PAGE_SHIFT),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_low_bound       (r_low_bound),
        .i_q_valid         (q_valid),
        .i_q_kind          (t_kind'(q_data[CMD_W-1:IDX_W])),
        .i_q_idx           (q_data[IDX_W-1:0]),
        .o_pop             (pop),
        .o_stat            (stat),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_status          (o_status),
        .o_granted_address (o_granted_address),
        .o_count_now       (o_count_now),
        .o_page_freed      (o_page_freed)
    );

endmodule

`default_nettype wire
